// File: rtl/bis_pkg.sv
`timescale 1ns / 1ps

package bis_pkg;

  localparam int DEF_AVG_TAPS   = 47;
  localparam int DEF_FIR_TAPS   = 37;
  localparam int DEF_DELTA_BITS = 24;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int MAX_TAPS = 64;
  localparam int TAB_IW   = 6;   // index bits of a MAX_TAPS table
  localparam int CHUNK_W  = 32;  // multiplier coefficient width
  localparam int WEIGHT_W = 2 * CHUNK_W;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_REARM  = 1'b1;

  typedef logic [WEIGHT_W-1:0] weight_row_t [MAX_TAPS];

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_FILL2,
    S_SUM,
    S_DIV,
    S_WLINE,
    S_FPRE,
    S_FIR,
    S_DRAIN,
    S_OUT
  } state_t;

  // Row taps-1 of Pascal's triangle, built at elaboration
  function automatic weight_row_t binom_row(input int taps);
    weight_row_t r;
    int row;
    int k;
    for (k = 0; k < MAX_TAPS; k++) begin
      r[k] = '0;
    end
    r[0] = WEIGHT_W'(1);
    for (row = 1; row < taps; row++) begin
      for (k = row; k > 0; k--) begin
        r[k] = r[k] + r[k-1];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/beat_interval_smoother_unit.sv
`timescale 1ns / 1ps

// Beat interval smoother. Each sample request (tuser = 0) pushes a raw tick
// interval into an AVG_TAPS moving-average window; the truncated average
// enters a FIR_TAPS line filtered with binomial weights C(FIR_TAPS-1, n) /
// 2^(FIR_TAPS-1), and the result comes out in unsigned fixed point with
// FRAC_BITS fraction bits, truncated. A re-arm request (tuser = 1) gives no
// result; the next sample then fills window and line with its own value
// (reset arms this fill too). One request is worked at a time and
// s_axis_tready is low while it runs. A single SUM_W x MB_W multiplier does
// all the multiplies: the divide by AVG_TAPS is one reciprocal multiply, and
// the FIR takes two passes per tap, low and high weight halves. A sample
// passes S_SUM, S_DIV, S_WLINE, S_FPRE, the S_FIR passes, S_DRAIN and S_OUT
// on its way to the result register; a refill sample goes through S_FILL and
// S_FILL2 in place of S_SUM, S_DIV and S_WLINE. The input is ready again the
// cycle after the result is loaded; a result held by the receiver stalls the
// next sample in S_OUT until it is taken. A re-arm request is done in S_IDLE.
// No clearing pass after reset is needed.
module beat_interval_smoother_unit
  import bis_pkg::*;
#(
  parameter int AVG_TAPS   = DEF_AVG_TAPS,
  parameter int FIR_TAPS   = DEF_FIR_TAPS,
  parameter int DELTA_BITS = DEF_DELTA_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // [DELTA_BITS-1:0] delta, zero padded to bytes
  input  logic [((DELTA_BITS+7)/8)*8-1:0]               s_axis_tdata,
  // [0] func
  input  logic [0:0]                                    s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // [DELTA_BITS+FRAC_BITS-1:0] filtered_delta, zero padded to bytes
  output logic [((DELTA_BITS+FRAC_BITS+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int OUT_W  = DELTA_BITS + FRAC_BITS;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int SUM_W  = DELTA_BITS + $clog2(AVG_TAPS);
  localparam int DIV_SH = SUM_W + $clog2(AVG_TAPS);
  localparam int RCP_W  = SUM_W + 1;
  localparam int MB_W   = (RCP_W > CHUNK_W) ? RCP_W : CHUNK_W;
  localparam int WP_W   = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int WC_W   = $clog2(AVG_TAPS + 1);
  localparam int LP_W   = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
  localparam int LC_W   = $clog2(FIR_TAPS + 1);
  localparam int PROD_W = SUM_W + MB_W;
  localparam int ACC_W  = DELTA_BITS + FIR_TAPS - 1;
  localparam int EXT_W  = ACC_W + FRAC_BITS;

  // ceil(2^DIV_SH / AVG_TAPS): exact quotient for every SUM_W-bit sum
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(AVG_TAPS - 1)) / 64'(AVG_TAPS));

  localparam weight_row_t WTAB = binom_row(FIR_TAPS);

  state_t state, state_next;

  logic                  refill_pending;
  logic [DELTA_BITS-1:0] delta_reg;

  // moving-average window, circular, oldest entry at wptr
  logic [DELTA_BITS-1:0] win_mem [AVG_TAPS];
  logic [DELTA_BITS-1:0] win_rd;
  logic [WP_W-1:0]       wptr;
  logic [WC_W-1:0]       win_cnt;   // samples written since the last fill
  logic [DELTA_BITS-1:0] win_fill;
  logic [SUM_W-1:0]      wsum;
  logic [SUM_W-1:0]      sum_new;
  logic [DELTA_BITS-1:0] win_old;

  // window sum held for the reciprocal multiply
  logic [SUM_W-1:0]      dq;
  logic [DELTA_BITS-1:0] avg_q;

  // average line, circular, newest entry at lptr
  logic [DELTA_BITS-1:0] line_mem [FIR_TAPS];
  logic [DELTA_BITS-1:0] line_rd;
  logic [LP_W-1:0]       lptr;
  logic [LP_W-1:0]       lptr_inc;
  logic [LP_W-1:0]       raddr;
  logic [LC_W-1:0]       line_cnt;
  logic [DELTA_BITS-1:0] line_fill;

  // FIR sequencing and shared multiplier
  logic [LP_W-1:0]       tap;
  logic                  ph;
  logic [SUM_W-1:0]      mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [WEIGHT_W-1:0]   wsel;
  logic [PROD_W-1:0]     prod;
  logic                  prod_hi;
  logic                  prod_vld;
  logic [ACC_W-1:0]      acc;
  logic [ACC_W-1:0]      acc_add;
  logic [EXT_W-1:0]      acc_ext;
  logic [OUT_W-1:0]      result;

  logic in_fire;
  logic out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && s_axis_tuser[0] == FUNC_SAMPLE) begin
          state_next = refill_pending ? S_FILL : S_SUM;
        end
      end
      S_FILL:  state_next = S_FILL2;
      S_FILL2: state_next = S_FPRE;
      S_SUM:   state_next = S_DIV;
      S_DIV:   state_next = S_WLINE;
      S_WLINE: state_next = S_FPRE;
      S_FPRE:  state_next = S_FIR;
      S_FIR: begin
        if (ph && tap == LP_W'(FIR_TAPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    wsel          = WTAB[TAB_IW'(tap)];
    if (state == S_FIR) begin
      mul_a = SUM_W'((LC_W'(tap) < line_cnt) ? line_rd : line_fill);
      mul_b = MB_W'(ph ? wsel[WEIGHT_W-1:CHUNK_W] : wsel[CHUNK_W-1:0]);
    end else if (state == S_DIV) begin
      mul_a = dq;
      mul_b = MB_W'(RECIP);
    end else begin
      mul_a = SUM_W'(delta_reg);
      mul_b = MB_W'(AVG_TAPS);
    end
  end

  assign win_old  = (win_cnt == WC_W'(AVG_TAPS)) ? win_rd : win_fill;
  assign sum_new  = wsum - SUM_W'(win_old) + SUM_W'(delta_reg);
  assign avg_q    = prod[DIV_SH +: DELTA_BITS];
  assign lptr_inc = (lptr == LP_W'(FIR_TAPS - 1)) ? '0 : lptr + 1'b1;
  assign acc_add  = prod_hi ? ACC_W'({prod, {CHUNK_W{1'b0}}}) : ACC_W'(prod);
  assign acc_ext  = (EXT_W'(acc) << FRAC_BITS) >> (FIR_TAPS - 1);
  assign result   = OUT_W'(acc_ext);

  // stores, no reset
  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      win_mem[wptr] <= delta_reg;
    end
    win_rd <= win_mem[wptr];
  end

  always_ff @(posedge clk) begin
    if (state == S_WLINE) begin
      line_mem[lptr_inc] <= avg_q;
    end
    line_rd <= line_mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta_reg <= s_axis_tdata[DELTA_BITS-1:0];
    end
    if (state == S_FILL || state == S_DIV || state == S_FIR) begin
      prod    <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_hi <= ph;
    end
    unique case (state)
      S_SUM: begin
        dq <= sum_new;
      end
      default: begin
      end
    endcase
    if (state == S_FILL2 || state == S_WLINE) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + acc_add;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      refill_pending <= 1'b1;
      wptr           <= '0;
      win_cnt        <= '0;
      wsum           <= '0;
      lptr           <= '0;
      line_cnt       <= '0;
      raddr          <= '0;
      tap            <= '0;
      ph             <= 1'b0;
      prod_vld       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      win_fill       <= '0;
      line_fill      <= '0;
      m_axis_tdata   <= '0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser[0] == FUNC_REARM) begin
              refill_pending <= 1'b1;
            end else if (refill_pending) begin
              refill_pending <= 1'b0;
              win_cnt        <= '0;
              line_cnt       <= '0;
              win_fill       <= s_axis_tdata[DELTA_BITS-1:0];
              line_fill      <= s_axis_tdata[DELTA_BITS-1:0];
            end
          end
        end
        S_FILL2: begin
          wsum  <= SUM_W'(prod);
          raddr <= lptr;
          tap   <= '0;
          ph    <= 1'b0;
        end
        S_SUM: begin
          wsum    <= sum_new;
          wptr    <= (wptr == WP_W'(AVG_TAPS - 1)) ? '0 : wptr + 1'b1;
          if (win_cnt != WC_W'(AVG_TAPS)) begin
            win_cnt <= win_cnt + 1'b1;
          end
        end
        S_WLINE: begin
          lptr  <= lptr_inc;
          raddr <= lptr_inc;
          tap   <= '0;
          ph    <= 1'b0;
          if (line_cnt != LC_W'(FIR_TAPS)) begin
            line_cnt <= line_cnt + 1'b1;
          end
        end
        S_FIR: begin
          prod_vld <= 1'b1;
          ph       <= !ph;
          if (!ph) begin
            raddr <= (raddr == '0) ? LP_W'(FIR_TAPS - 1) : raddr - 1'b1;
          end else if (tap != LP_W'(FIR_TAPS - 1)) begin
            tap <= tap + 1'b1;
          end
        end
        S_DRAIN: begin
          prod_vld <= 1'b0;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_TW'(result);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a sample request always starts either a fill or a window update
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tuser[0] == FUNC_SAMPLE) |=> (state == S_SUM || state == S_FILL))
    else $error("sample request did not start processing");

  // the window average must fit the line entry width
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WLINE) |-> ((prod >> (DIV_SH + DELTA_BITS)) == '0))
    else $error("window average overflows entry width");

  // products only accumulate during the FIR pass
  assert property (@(posedge clk) disable iff (rst)
    prod_vld |-> (state == S_FIR || state == S_DRAIN))
    else $error("stray product accumulation");

  // fill counts never pass their store depths
  assert property (@(posedge clk) disable iff (rst)
    (win_cnt <= WC_W'(AVG_TAPS)) && (line_cnt <= LC_W'(FIR_TAPS)))
    else $error("fill count beyond store depth");

  // finishing a sample leaves a result on the output
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (m_axis_tvalid && state == S_IDLE))
    else $error("result not presented");

endmodule

// File: test/tb_beat_interval_smoother_unit.sv
`timescale 1ns / 1ps

module tb_beat_interval_smoother_unit;
  import bis_pkg::*;

  localparam int AVG_N   = DEF_AVG_TAPS;
  localparam int FIR_N   = DEF_FIR_TAPS;
  localparam int DW      = DEF_DELTA_BITS;
  localparam int FRAC_N  = DEF_FRAC_BITS;
  localparam int DATA_W  = ((DW + 7) / 8) * 8;
  localparam int RES_W   = ((DW + FRAC_N + 7) / 8) * 8;
  localparam int SAMPLE_GOAL = 1060;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 500;
  localparam int TAIL_CYCLES = 150;

  typedef struct {
    logic [0:0]    func;
    logic [DW-1:0] delta;
    bit            quiet;        // no idling on either side around this request
    bit            drain_first;  // hold off until every pending result has come
  } req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // [23:0] delta
  logic [0:0]        s_axis_tuser = '0;   // [0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [RES_W-1:0]  m_axis_tdata;        // [39:0] filtered_delta

  req_t             pending_reqs[$];
  logic [RES_W-1:0] sums_due[$];
  int               err_count = 0;
  int               sums_seen = 0;
  int               cycles = 0;
  int               src_gap = 0;
  int               sink_hold = 0;
  bit               calm_phase = 1'b0;

  // predictor state
  logic [63:0]   binom_wt [FIR_N];
  logic [DW-1:0] win_hist [AVG_N];
  logic [DW-1:0] avg_hist [FIR_N];
  logic [29:0]   win_total = '0;
  bit            refill_armed = 1'b1;

  beat_interval_smoother_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Work out the smoothed interval for one accepted request
  task automatic smooth_interval(input logic [0:0] op, input logic [DW-1:0] d);
    logic [DW-1:0] mean;
    logic [63:0]   acc;
    int            i;
    if (op == FUNC_REARM) begin
      refill_armed = 1'b1;
      return;
    end
    if (refill_armed) begin
      refill_armed = 1'b0;
      for (i = 0; i < AVG_N; i++) win_hist[i] = d;
      win_total = 30'(64'(d) * AVG_N);
      mean = DW'(win_total / 30'(AVG_N));
      for (i = 0; i < FIR_N; i++) avg_hist[i] = mean;
    end else begin
      win_total = win_total - 30'(win_hist[AVG_N-1]) + 30'(d);
      for (i = AVG_N - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
      win_hist[0] = d;
      mean = DW'(win_total / 30'(AVG_N));
      for (i = FIR_N - 1; i > 0; i--) avg_hist[i] = avg_hist[i-1];
      avg_hist[0] = mean;
    end
    acc = '0;
    for (i = 0; i < FIR_N; i++) acc += binom_wt[i] * 64'(avg_hist[i]);
    sums_due.push_back(RES_W'(acc >> (FIR_N - 1 - FRAC_N)));
  endtask

  task automatic add_req(input logic [0:0] f, input logic [DW-1:0] d, input bit q,
                         input bit drain);
    req_t r;
    r.func = f;
    r.delta = d;
    r.quiet = q;
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endtask

  // Source side
  always @(posedge clk) begin
    req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) smooth_interval(s_axis_tuser, s_axis_tdata[DW-1:0]);
      if (src_gap > 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain_first && sums_due.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (!pending_reqs[0].quiet && $urandom_range(0, 5) == 0) begin
        src_gap       <= $urandom_range(0, 11);
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.func;
        s_axis_tdata  <= DATA_W'(nxt.delta);
        calm_phase    <= nxt.quiet;
      end
    end
  end

  // Sink side
  always @(posedge clk) begin
    logic [RES_W-1:0] want;
    bit               took;
    took = 1'b0;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        took = 1'b1;
        sums_seen++;
        if (sums_due.size() == 0) begin
          $error("filtered_delta: expected nothing, got %0h", m_axis_tdata);
          err_count++;
        end else begin
          want = sums_due.pop_front();
          if (m_axis_tdata !== want) begin
            $error("filtered_delta: expected %0h, got %0h", want, m_axis_tdata);
            err_count++;
          end
        end
      end
      // long back-pressure so the block holds its result and stalls its input
      if (took && (sums_seen == 250 || sums_seen == 700)) begin
        sink_hold     <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (sink_hold > 0) begin
        sink_hold     <= sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        sink_hold     <= $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("beat_interval_smoother_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int            k;
    int            j;
    int            samples;
    int            mode;
    int            seg_len;
    int            rearms;
    bit            q;
    bit            drain;
    logic [DW-1:0] base;
    logic [DW-1:0] d;

    binom_wt[0] = 64'd1;
    for (k = 1; k < FIR_N; k++) binom_wt[k] = binom_wt[k-1] * 64'(FIR_N - k) / 64'(k);
    for (k = 0; k < AVG_N; k++) win_hist[k] = '0;
    for (k = 0; k < FIR_N; k++) avg_hist[k] = '0;

    // directed: reset refill, extremes, repeated re-arm, ignored delta on re-arm
    add_req(FUNC_SAMPLE, '0, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '1, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '1, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '0, 1'b0, 1'b0);
    add_req(FUNC_REARM,  '1, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '1, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '0, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, 24'hAAAAAA, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, 24'h555555, 1'b0, 1'b0);
    add_req(FUNC_REARM,  '0, 1'b0, 1'b0);
    add_req(FUNC_REARM,  24'h5A5A5A, 1'b0, 1'b0);
    add_req(FUNC_REARM,  '1, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, 24'h123456, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, 24'h000001, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, 24'h800000, 1'b0, 1'b0);
    add_req(FUNC_REARM,  24'h000001, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '0, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, '1, 1'b0, 1'b0);
    add_req(FUNC_SAMPLE, 24'h7FFFFF, 1'b0, 1'b0);
    add_req(FUNC_REARM,  24'hA5A5A5, 1'b0, 1'b1);
    add_req(FUNC_SAMPLE, 24'h000400, 1'b0, 1'b0);

    // random: segments of jittery intervals, each mostly started by a re-arm
    samples = 0;
    while (samples < SAMPLE_GOAL) begin
      mode    = $urandom_range(0, 5);
      seg_len = $urandom_range(15, 80);
      q       = ($urandom_range(0, 3) == 0);
      drain   = ($urandom_range(0, 7) == 0);
      base    = DW'($urandom);
      rearms  = $urandom_range(0, 2);
      for (j = 0; j < rearms; j++) begin
        add_req(FUNC_REARM, DW'($urandom), q, drain);
        drain = 1'b0;
      end
      for (j = 0; j < seg_len; j++) begin
        case (mode)
          0, 1, 2: d = base ^ (DW'($urandom) >> $urandom_range(8, 23));
          3: d = DW'($urandom);
          4: d = ($urandom_range(0, 1) == 0) ? '1 : '0;
          default: d = DW'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 39) == 0) add_req(FUNC_REARM, DW'($urandom), q, 1'b0);
        add_req(FUNC_SAMPLE, d, q, drain);
        drain = 1'b0;
        samples++;
      end
    end
    for (k = (pending_reqs.size() > 150) ? pending_reqs.size() - 150 : 0;
         k < pending_reqs.size(); k++) begin
      pending_reqs[k].quiet = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid || sums_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("beat_interval_smoother_unit: match");
    end else begin
      $display("beat_interval_smoother_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bis_pkg.sv
rtl/beat_interval_smoother_unit.sv
test/tb_beat_interval_smoother_unit.sv
